// ===== design/cluster_occupancy_event_filter_top_defines.svh =====
// ----------------------------------------------------------------------------
// Cluster occupancy event filter - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CLUSTER_OCCUPANCY_EVENT_FILTER_TOP_DEFINES_SVH
`define CLUSTER_OCCUPANCY_EVENT_FILTER_TOP_DEFINES_SVH

// Same-cycle implication
`define COFE_ASSERT_IMPLY(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("cofe assertion failed: same-cycle implication");

// Next-cycle implication
`define COFE_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("cofe assertion failed: next-cycle implication");

`endif

// ===== design/cofe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cofe_pkg
// Types, constants and helpers shared by the cluster occupancy event filter.
// ----------------------------------------------------------------------------
package cofe_pkg;

	// Geometry and counter sizing
	localparam int NUM_BOARDS         = 2;
	localparam int CHANNELS_PER_BOARD = 24;
	localparam int COUNT_BITS         = 8;

	localparam int LADDERS   = NUM_BOARDS * CHANNELS_PER_BOARD;
	localparam int RAM_DEPTH = 2 * LADDERS;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// Budget holds -1 .. 255
	localparam int BUDGET_W = 9;
	localparam int THR_W    = 9;
	localparam int CMP_W    = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

	localparam int TOTAL_W = 12;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	localparam int MASK_W     = 48;
	localparam int MASK_IDX_W = $clog2(MASK_W);

	// Configuration port
	localparam int APB_DW    = 64;
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W    = REG_IDX_W + 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MIN_CLUSTERS    = 3'd0,
		REG_MAX_CLUSTERS    = 3'd1,
		REG_LADDER_LIMIT_S  = 3'd2,
		REG_LADDER_LIMIT_K  = 3'd3,
		REG_SAFETY_S        = 3'd4,
		REG_SAFETY_K        = 3'd5,
		REG_EXCLUDED_MASK_S = 3'd6,
		REG_EXCLUDED_MASK_K = 3'd7
	} cofe_reg_e_t;

	typedef enum logic [2:0] {
		REASON_OK       = 3'd0,
		REASON_EMPTY    = 3'd1,
		REASON_S_BUDGET = 3'd2,
		REASON_K_BUDGET = 3'd3,
		REASON_WINDOW   = 3'd4
	} cofe_reason_t;

	// Command bit of an input item
	localparam logic CMD_END_OF_EVENT = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic       board_number;
		logic [4:0] channel_number;
		logic [5:0] ladder_position;
		logic       side_k;
	} cofe_in_t;

	typedef struct packed {
		logic               accept;
		logic [2:0]         reason;
		logic [TOTAL_W-1:0] kept_count;
	} cofe_out_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] min_clusters;
		logic [TOTAL_W-1:0] max_clusters;
		logic [7:0]         per_ladder_limit_s;
		logic [7:0]         per_ladder_limit_k;
		logic [7:0]         safety_s;
		logic [7:0]         safety_k;
		logic [MASK_W-1:0]  excluded_mask_s;
		logic [MASK_W-1:0]  excluded_mask_k;
	} cofe_cfg_t;

	// Budget reload that goes with a safety register write
	typedef struct packed {
		logic       load_s;
		logic       load_k;
		logic [7:0] value;
	} cofe_reload_t;

	// Counter memory address: S side ladders first, then K side
	function automatic logic [RAM_AW-1:0] ladder_addr(input logic side, input logic [5:0] lad);
		logic [RAM_AW-1:0] addr;
		addr = '0;
		if (32'(lad) < LADDERS) begin
			addr = side ? RAM_AW'(LADDERS + 32'(lad)) : RAM_AW'(lad);
		end
		return addr;
	endfunction

endpackage

// ===== design/cluster_occupancy_event_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_occupancy_event_filter_top
// Per-event cluster occupancy filter: counts kept clusters per ladder and
// side, spends safety budget on overfull ladders, emits one verdict per event.
//
//   channel   direction  handshake                     payload
//   cluster   in         cluster_valid / cluster_stall  cofe_in_t
//   verdict   out        verdict_valid / verdict_stall  cofe_out_t
//   config    in/out     psel/penable/pwrite/pready     paddr, pwdata, prdata
//
// One item per cycle unless the input stalls: an item is registered, evaluated against the ladder
// counter memory (read as it is taken, last write forwarded) in the next cycle.
// An end-of-event request passes the input register, then loads the verdict register.
// The input stalls only when an end-of-event waits on a full, stalled verdict
// register; a cluster in the input register never holds up the input.
// Reset clears all counters at once through per-entry valid bits, no sweep.
// ----------------------------------------------------------------------------
module cluster_occupancy_event_filter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cluster_valid,
	output logic                          cluster_stall,
	input  cofe_pkg::cofe_in_t            cluster,
	output logic                          verdict_valid,
	input  logic                          verdict_stall,
	output cofe_pkg::cofe_out_t           verdict,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cofe_pkg::ADDR_W-1:0]   paddr,
	input  logic [cofe_pkg::APB_DW-1:0]   pwdata,
	output logic [cofe_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	cofe_pkg::cofe_cfg_t    cfg;
	cofe_pkg::cofe_reload_t reload;
	cofe_pkg::cofe_in_t     item_s1;
	cofe_pkg::cofe_out_t    core_verdict;
	cofe_pkg::cofe_out_t    verdict_q;
	logic                   valid_s1;
	logic                   verdict_valid_q;
	logic                   s1_fire;

	cofe_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.reload  (reload)
	);

	// Stage 1 completes unless an end-of-event meets a blocked verdict register
	assign s1_fire = valid_s1 && ((item_s1.cmd != cofe_pkg::CMD_END_OF_EVENT)
		|| !verdict_valid_q || !verdict_stall);
	assign cluster_stall = valid_s1 && !s1_fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cluster_stall) begin
			valid_s1 <= cluster_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cluster_valid && !cluster_stall) begin
			item_s1 <= cluster;
		end
	end

	cofe_event_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.reload  (reload),
		.lookup  (cluster),
		.item_s1 (item_s1),
		.fire    (s1_fire),
		.verdict (core_verdict)
	);

	// Verdict register: load on end of event, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (s1_fire && (item_s1.cmd == cofe_pkg::CMD_END_OF_EVENT)) begin
			verdict_valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && (item_s1.cmd == cofe_pkg::CMD_END_OF_EVENT)) begin
			verdict_q <= core_verdict;
		end
	end

	assign verdict_valid = verdict_valid_q;
	assign verdict       = verdict_q;

endmodule

// ===== design/cofe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cofe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cofe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port; read returns the old word on collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/cofe_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cofe_cfg_regs
// APB-style register file holding the filter thresholds and exclusion masks.
// ----------------------------------------------------------------------------
module cofe_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cofe_pkg::ADDR_W-1:0]   paddr,
	input  logic [cofe_pkg::APB_DW-1:0]   pwdata,
	output logic [cofe_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output cofe_pkg::cofe_cfg_t           cfg,
	output cofe_pkg::cofe_reload_t        reload
);

	cofe_pkg::cofe_cfg_t   cfg_q;
	cofe_pkg::cofe_reg_e_t reg_idx;
	logic                  wr_en;

	assign pready  = 1'b1;
	assign reg_idx = cofe_pkg::cofe_reg_e_t'(paddr[cofe_pkg::ADDR_W-1:3]);
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	// Reload the side budget in the same edge as its safety write
	assign reload.load_s = wr_en && (reg_idx == cofe_pkg::REG_SAFETY_S);
	assign reload.load_k = wr_en && (reg_idx == cofe_pkg::REG_SAFETY_K);
	assign reload.value  = pwdata[7:0];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_clusters       <= '0;
			cfg_q.max_clusters       <= '1;
			cfg_q.per_ladder_limit_s <= '1;
			cfg_q.per_ladder_limit_k <= '1;
			cfg_q.safety_s           <= '0;
			cfg_q.safety_k           <= '0;
			cfg_q.excluded_mask_s    <= '0;
			cfg_q.excluded_mask_k    <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				cofe_pkg::REG_MIN_CLUSTERS: begin
					cfg_q.min_clusters <= pwdata[cofe_pkg::TOTAL_W-1:0];
				end
				cofe_pkg::REG_MAX_CLUSTERS: begin
					cfg_q.max_clusters <= pwdata[cofe_pkg::TOTAL_W-1:0];
				end
				cofe_pkg::REG_LADDER_LIMIT_S: begin
					cfg_q.per_ladder_limit_s <= pwdata[7:0];
				end
				cofe_pkg::REG_LADDER_LIMIT_K: begin
					cfg_q.per_ladder_limit_k <= pwdata[7:0];
				end
				cofe_pkg::REG_SAFETY_S: begin
					cfg_q.safety_s <= pwdata[7:0];
				end
				cofe_pkg::REG_SAFETY_K: begin
					cfg_q.safety_k <= pwdata[7:0];
				end
				cofe_pkg::REG_EXCLUDED_MASK_S: begin
					cfg_q.excluded_mask_s <= pwdata[cofe_pkg::MASK_W-1:0];
				end
				cofe_pkg::REG_EXCLUDED_MASK_K: begin
					cfg_q.excluded_mask_k <= pwdata[cofe_pkg::MASK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			cofe_pkg::REG_MIN_CLUSTERS:    prdata = cofe_pkg::APB_DW'(cfg_q.min_clusters);
			cofe_pkg::REG_MAX_CLUSTERS:    prdata = cofe_pkg::APB_DW'(cfg_q.max_clusters);
			cofe_pkg::REG_LADDER_LIMIT_S:  prdata = cofe_pkg::APB_DW'(cfg_q.per_ladder_limit_s);
			cofe_pkg::REG_LADDER_LIMIT_K:  prdata = cofe_pkg::APB_DW'(cfg_q.per_ladder_limit_k);
			cofe_pkg::REG_SAFETY_S:        prdata = cofe_pkg::APB_DW'(cfg_q.safety_s);
			cofe_pkg::REG_SAFETY_K:        prdata = cofe_pkg::APB_DW'(cfg_q.safety_k);
			cofe_pkg::REG_EXCLUDED_MASK_S: prdata = cofe_pkg::APB_DW'(cfg_q.excluded_mask_s);
			cofe_pkg::REG_EXCLUDED_MASK_K: prdata = cofe_pkg::APB_DW'(cfg_q.excluded_mask_k);
			default:                       prdata = '0;
		endcase
	end

endmodule

// ===== design/cofe_event_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cofe_event_core
// Per-event state: ladder counter memory, side budgets, totals and verdict.
// ----------------------------------------------------------------------------
module cofe_event_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cofe_pkg::cofe_cfg_t    cfg,
	input  cofe_pkg::cofe_reload_t reload,
	input  cofe_pkg::cofe_in_t     lookup,
	input  cofe_pkg::cofe_in_t     item_s1,
	input  logic                   fire,
	output cofe_pkg::cofe_out_t    verdict
);

	localparam int AW = cofe_pkg::RAM_AW;
	localparam int CW = cofe_pkg::COUNT_BITS;
	localparam int BW = cofe_pkg::BUDGET_W;
	localparam int TW = cofe_pkg::TOTAL_W;

	logic [AW-1:0]                    rd_addr;
	logic [AW-1:0]                    addr_s1;
	logic [CW-1:0]                    ram_rdata;
	logic [CW-1:0]                    cnt_old;
	logic [CW-1:0]                    cnt_new;
	logic [cofe_pkg::RAM_DEPTH-1:0]   entry_valid_q;
	logic                             fwd_valid_q;
	logic [AW-1:0]                    fwd_addr_q;
	logic [CW-1:0]                    fwd_data_q;

	logic signed [BW-1:0]             budget_s_q;
	logic signed [BW-1:0]             budget_k_q;
	logic signed [BW-1:0]             budget_sel;
	logic signed [BW-1:0]             budget_dec;
	logic [TW-1:0]                    total_seen_q;
	logic [TW-1:0]                    kept_total_q;
	cofe_pkg::cofe_reason_t           reject_q;
	cofe_pkg::cofe_reason_t           reason;

	logic                             is_cluster;
	logic                             is_eoe;
	logic                             board_ok;
	logic [cofe_pkg::MASK_IDX_W-1:0]  excl_bit;
	logic [cofe_pkg::MASK_W-1:0]      mask_sel;
	logic                             excluded;
	logic                             keep;
	logic                             lad_ok;
	logic                             ram_we;
	logic [cofe_pkg::THR_W-1:0]       thr;
	logic                             spend;
	logic [TW:0]                      kept_ext;
	logic                             below_win;
	logic                             above_win;

	assign is_cluster = fire && (item_s1.cmd != cofe_pkg::CMD_END_OF_EVENT);
	assign is_eoe     = fire && (item_s1.cmd == cofe_pkg::CMD_END_OF_EVENT);

	// Counter memory: read for the incoming item, write back from stage 1
	assign rd_addr = cofe_pkg::ladder_addr(lookup.side_k, lookup.ladder_position);
	assign addr_s1 = cofe_pkg::ladder_addr(item_s1.side_k, item_s1.ladder_position);

	cofe_ram #(
		.WIDTH (CW),
		.DEPTH (cofe_pkg::RAM_DEPTH)
	) u_count_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (cnt_new),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Take the word just written when the next item hits the same ladder
	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == addr_s1)) begin
			cnt_old = fwd_data_q;
		end else if (entry_valid_q[addr_s1]) begin
			cnt_old = ram_rdata;
		end else begin
			cnt_old = '0;
		end
	end

	// Exclusion test on the readout channel index (board and channel)
	assign board_ok = (32'(item_s1.board_number) < cofe_pkg::NUM_BOARDS)
		&& (32'(item_s1.channel_number) < cofe_pkg::CHANNELS_PER_BOARD);
	assign excl_bit = cofe_pkg::MASK_IDX_W'(item_s1.board_number
		? cofe_pkg::CHANNELS_PER_BOARD : 0) + cofe_pkg::MASK_IDX_W'(item_s1.channel_number);
	assign mask_sel = item_s1.side_k ? cfg.excluded_mask_k : cfg.excluded_mask_s;
	assign excluded = board_ok && mask_sel[excl_bit];

	assign keep   = is_cluster && (reject_q == cofe_pkg::REASON_OK) && !excluded;
	assign lad_ok = 32'(item_s1.ladder_position) < cofe_pkg::LADDERS;
	assign ram_we = keep && lad_ok;

	// Saturating ladder count and threshold check
	assign cnt_new = (cnt_old == cofe_pkg::COUNT_MAX) ? cnt_old : cnt_old + CW'(1);
	assign thr = item_s1.side_k
		? ({1'b0, cfg.per_ladder_limit_k} + {1'b0, cfg.safety_k})
		: ({1'b0, cfg.per_ladder_limit_s} + {1'b0, cfg.safety_s});
	assign spend = ram_we && (cofe_pkg::CMP_W'(cnt_new) >= cofe_pkg::CMP_W'(thr));

	assign budget_sel = item_s1.side_k ? budget_k_q : budget_s_q;
	assign budget_dec = budget_sel - BW'(1);

	// Event state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			fwd_valid_q   <= 1'b0;
			budget_s_q    <= '0;
			budget_k_q    <= '0;
			total_seen_q  <= '0;
			kept_total_q  <= '0;
			reject_q      <= cofe_pkg::REASON_OK;
		end else begin
			fwd_valid_q <= ram_we;
			if (is_eoe) begin
				entry_valid_q <= '0;
				budget_s_q    <= $signed({1'b0, cfg.safety_s});
				budget_k_q    <= $signed({1'b0, cfg.safety_k});
				total_seen_q  <= '0;
				kept_total_q  <= '0;
				reject_q      <= cofe_pkg::REASON_OK;
			end else begin
				if (reload.load_s) begin
					budget_s_q <= $signed({1'b0, reload.value});
				end
				if (reload.load_k) begin
					budget_k_q <= $signed({1'b0, reload.value});
				end
				if (is_cluster && (total_seen_q != cofe_pkg::TOTAL_MAX)) begin
					total_seen_q <= total_seen_q + TW'(1);
				end
				if (keep && (kept_total_q != cofe_pkg::TOTAL_MAX)) begin
					kept_total_q <= kept_total_q + TW'(1);
				end
				if (ram_we) begin
					entry_valid_q[addr_s1] <= 1'b1;
				end
				if (spend) begin
					if (item_s1.side_k) begin
						budget_k_q <= budget_dec;
					end else begin
						budget_s_q <= budget_dec;
					end
					if (budget_dec < 0) begin
						reject_q <= item_s1.side_k ? cofe_pkg::REASON_K_BUDGET
							: cofe_pkg::REASON_S_BUDGET;
					end
				end
			end
		end
	end

	// Hold the last write for forwarding
	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s1;
		fwd_data_q <= cnt_new;
	end

	// Verdict: empty first, then a spent budget, then the count window
	assign kept_ext  = {1'b0, kept_total_q};
	assign below_win = (kept_ext + (TW + 1)'(1)) < {1'b0, cfg.min_clusters};
	assign above_win = kept_ext > ({1'b0, cfg.max_clusters} + (TW + 1)'(1));

	always_comb begin
		if (total_seen_q == '0) begin
			reason = cofe_pkg::REASON_EMPTY;
		end else if (reject_q != cofe_pkg::REASON_OK) begin
			reason = reject_q;
		end else if (below_win || above_win) begin
			reason = cofe_pkg::REASON_WINDOW;
		end else begin
			reason = cofe_pkg::REASON_OK;
		end
	end

	assign verdict.accept     = (reason == cofe_pkg::REASON_OK);
	assign verdict.reason     = reason;
	assign verdict.kept_count = kept_total_q;

endmodule

// ===== design/cofe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cofe_checker
// Port-level checks on the filter's cluster and verdict channels.
// ----------------------------------------------------------------------------
`include "cluster_occupancy_event_filter_top_defines.svh"

module cofe_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cluster_valid,
	input logic                cluster_stall,
	input cofe_pkg::cofe_in_t  cluster,
	input logic                verdict_valid,
	input logic                verdict_stall,
	input cofe_pkg::cofe_out_t verdict
);

	// Hold a stalled verdict
	`COFE_ASSERT_NEXT(a_verdict_hold, verdict_valid && verdict_stall, verdict_valid && $stable(verdict))

	// Input backs up only behind a stalled, full verdict register
	`COFE_ASSERT_IMPLY(a_stall_cause, cluster_stall, verdict_valid && verdict_stall)

	// A fresh verdict follows an end-of-event request taken at the input earlier
	`COFE_ASSERT_IMPLY(a_verdict_source, $rose(verdict_valid), $past(cluster_valid && !cluster_stall && cluster.cmd, 2))

endmodule

bind cluster_occupancy_event_filter_top cofe_checker u_cofe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cluster_valid (cluster_valid),
	.cluster_stall (cluster_stall),
	.cluster       (cluster),
	.verdict_valid (verdict_valid),
	.verdict_stall (verdict_stall),
	.verdict       (verdict)
);
